FILE: rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the sorted leaf table: request and status
// codes and the fixed widths of the record id fields.
// ----------------------------------------------------------------------------
package slt_pkg;

    // record id field widths
    localparam int PAGE_W = 31;
    localparam int SLOT_W = 32;

    // request codes
    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_LOCATE   = 3'd1;
    localparam logic [2:0] REQ_READ     = 3'd2;
    localparam logic [2:0] REQ_SET_NEXT = 3'd3;
    localparam logic [2:0] REQ_SPLIT    = 3'd4;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_NOT_FULL  = 3'd4,
        ST_BAD_ARG   = 3'd5
    } status_t;

endpackage

FILE: rtl/slt_entry_ram.sv
// ----------------------------------------------------------------------------
// slt_entry_ram
// Entry store of the leaf table: one write port, one read port with
// registered read data. Each word packs key, record page and record slot.
// ----------------------------------------------------------------------------
module slt_entry_ram #(
    parameter int DEPTH  = 64,
    parameter int KEY_W  = 32,
    parameter int ADDR_W = 6
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [ADDR_W-1:0]                            waddr,
    input  logic [KEY_W+slt_pkg::PAGE_W+slt_pkg::SLOT_W-1:0] wdata,
    input  logic                                         re,
    input  logic [ADDR_W-1:0]                            raddr,
    output logic [KEY_W+slt_pkg::PAGE_W+slt_pkg::SLOT_W-1:0] rdata
);
    import slt_pkg::*;

    localparam int ENTRY_W = KEY_W + PAGE_W + SLOT_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sorted_leaf_table_with_split.sv
// ----------------------------------------------------------------------------
// sorted_leaf_table_with_split
// One leaf node of a B+ tree: a sorted key / record id table with entry
// count, sibling pointer and split-insert.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in_valid / in_ready channel, results leave on
// the out_valid / out_ready channel; a transfer happens when valid and ready
// are both high. in_ready is high only while no request is in progress.
// Every request gives one result (last = 1), except a successful split,
// which gives one result per sibling entry with last on the final one.
// All work goes through one entry RAM port pair, one entry per cycle; split
// emission waits while the output register is full. Steps per request:
//   insert      downward compare-and-shift, then placement
//   locate      upward compare scan
//   read entry  RAM read; set next and rejected requests answer directly
//   split       emit the sibling entries, with the new key merged in when it
//               joins the sibling; otherwise emit, then a local insert
// Results sit in an output register; the next request is taken while a
// result waits there. When the receiver stalls, the sequencer holds at its
// next result until the register frees. Reset empties the table, clears
// the sibling pointer and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_leaf_table_with_split #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] key,
    input  logic [30:0]        rid_page,
    input  logic signed [31:0] rid_slot,
    input  logic [6:0]         index,
    input  logic signed [31:0] next_ptr,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [6:0]         position,
    output logic signed [31:0] out_key,
    output logic [30:0]        out_page,
    output logic signed [31:0] out_slot,
    output logic [30:0]        link_ptr,
    output logic [6:0]         entry_count,
    output logic               last
);
    import slt_pkg::*;

    localparam int KW      = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int KEEP    = (CAPACITY + 1) / 2;
    localparam int ENTRY_W = KW + PAGE_W + SLOT_W;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SHIFT     = 9'b000000010,
        S_PLACE     = 9'b000000100,
        S_SCAN      = 9'b000001000,
        S_READ      = 9'b000010000,
        S_RESP      = 9'b000100000,
        S_SPLIT_CHK = 9'b001000000,
        S_EMIT      = 9'b010000000,
        S_EMIT_NEW  = 9'b100000000
    } state_t;

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [30:0]     link_reg, link_next;
    logic            out_valid_reg, out_valid_next;

    // sequencer working registers
    logic [CW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   sib_reg, sib_next;
    logic            new_done_reg, new_done_next;
    logic            local_reg, local_next;

    // latched request
    logic signed [KW-1:0] req_key_reg, req_key_next;
    logic [PAGE_W-1:0]    req_page_reg, req_page_next;
    logic [SLOT_W-1:0]    req_slot_reg, req_slot_next;

    // pending single result
    status_t            res_status_reg, res_status_next;
    logic [6:0]         res_pos_reg, res_pos_next;
    logic signed [31:0] res_key_reg, res_key_next;
    logic [30:0]        res_page_reg, res_page_next;
    logic signed [31:0] res_slot_reg, res_slot_next;

    // output register
    status_t            out_status_reg;
    logic [6:0]         out_pos_reg;
    logic signed [31:0] out_key_reg;
    logic [30:0]        out_page_reg;
    logic signed [31:0] out_slot_reg;
    logic [30:0]        out_link_reg;
    logic [6:0]         out_count_reg;
    logic               out_last_reg;

    // output load values
    logic               out_load;
    status_t            ld_status;
    logic [6:0]         ld_pos;
    logic signed [31:0] ld_key;
    logic [30:0]        ld_page;
    logic signed [31:0] ld_slot;
    logic [6:0]         ld_count;
    logic               ld_last;

    // ram port signals
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic signed [KW-1:0] rd_key;
    logic [PAGE_W-1:0]    rd_page;
    logic [SLOT_W-1:0]    rd_slot;
    logic signed [KW-1:0] in_key_kw;
    logic [CW-1:0]        fill_dec;
    logic [CW-1:0]        cur_dec;
    logic [CW-1:0]        cur_inc;
    logic [ENTRY_W-1:0]   new_entry;
    logic                 out_free;

    slt_entry_ram #(
        .DEPTH  (CAPACITY),
        .KEY_W  (KW),
        .ADDR_W (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // unpack read word and helpers
    assign rd_key    = ram_rdata[ENTRY_W-1 -: KW];
    assign rd_page   = ram_rdata[PAGE_W+SLOT_W-1 -: PAGE_W];
    assign rd_slot   = ram_rdata[SLOT_W-1:0];
    assign in_key_kw = key[KW-1:0];
    assign fill_dec  = fill_reg - CW'(1);
    assign cur_dec   = cur_reg - CW'(1);
    assign cur_inc   = cur_reg + CW'(1);
    assign new_entry = {req_key_reg, req_page_reg, req_slot_reg};
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        link_next       = link_reg;
        cur_next        = cur_reg;
        sib_next        = sib_reg;
        new_done_next   = new_done_reg;
        local_next      = local_reg;
        req_key_next    = req_key_reg;
        req_page_next   = req_page_reg;
        req_slot_next   = req_slot_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_key_next    = res_key_reg;
        res_page_next   = res_page_reg;
        res_slot_next   = res_slot_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg[IW-1:0];
        ram_wdata       = new_entry;
        ram_re          = 1'b0;
        ram_raddr       = cur_inc[IW-1:0];
        out_load        = 1'b0;
        ld_status       = res_status_reg;
        ld_pos          = res_pos_reg;
        ld_key          = res_key_reg;
        ld_page         = res_page_reg;
        ld_slot         = res_slot_reg;
        ld_count        = 7'(fill_reg);
        ld_last         = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_key_next    = in_key_kw;
                    req_page_next   = rid_page;
                    req_slot_next   = rid_slot;
                    res_status_next = ST_OK;
                    res_pos_next    = '0;
                    res_key_next    = '0;
                    res_page_next   = '0;
                    res_slot_next   = '0;
                    local_next      = 1'b0;
                    state_next      = S_RESP;
                    unique case (req_type)
                        REQ_INSERT:
                        begin
                            if (in_key_kw == '0)
                            begin
                                res_status_next = ST_BAD_ARG;
                            end
                            else if (fill_reg == CW'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (fill_reg == '0)
                            begin
                                cur_next   = '0;
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = fill_dec[IW-1:0];
                                cur_next   = fill_dec;
                                state_next = S_SHIFT;
                            end
                        end
                        REQ_LOCATE:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                cur_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_READ:
                        begin
                            if (index >= 7'(fill_reg))
                            begin
                                res_status_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = index[IW-1:0];
                                res_pos_next = index;
                                state_next   = S_READ;
                            end
                        end
                        REQ_SET_NEXT:
                        begin
                            if (next_ptr[31])
                            begin
                                res_status_next = ST_BAD_ARG;
                            end
                            else
                            begin
                                link_next = next_ptr[30:0];
                            end
                        end
                        REQ_SPLIT:
                        begin
                            if (in_key_kw == '0)
                            begin
                                res_status_next = ST_BAD_ARG;
                            end
                            else if (fill_reg != CW'(CAPACITY))
                            begin
                                res_status_next = ST_NOT_FULL;
                            end
                            else
                            begin
                                fill_next  = CW'(KEEP);
                                ram_re     = 1'b1;
                                ram_raddr  = IW'(KEEP);
                                state_next = S_SPLIT_CHK;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_BAD_ARG;
                        end
                    endcase
                end
            end

            // walk down, moving every key that is not less up one slot
            S_SHIFT:
            begin
                if (!(rd_key < req_key_reg))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_inc[IW-1:0];
                    ram_wdata = ram_rdata;
                    if (cur_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cur_dec[IW-1:0];
                        cur_next  = cur_dec;
                    end
                end
                else
                begin
                    cur_next   = cur_inc;
                    state_next = S_PLACE;
                end
            end

            // write the new entry into the opened slot
            S_PLACE:
            begin
                ram_we       = 1'b1;
                ram_waddr    = cur_reg[IW-1:0];
                ram_wdata    = new_entry;
                fill_next    = fill_reg + CW'(1);
                res_pos_next = 7'(cur_reg);
                state_next   = local_reg ? S_IDLE : S_RESP;
            end

            // walk up to the first key that is not less
            S_SCAN:
            begin
                if (rd_key < req_key_reg)
                begin
                    if (cur_inc == fill_reg)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_pos_next    = 7'(cur_inc);
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cur_inc[IW-1:0];
                        cur_next  = cur_inc;
                    end
                end
                else
                begin
                    res_status_next = (rd_key == req_key_reg) ? ST_OK : ST_NOT_FOUND;
                    res_pos_next    = 7'(cur_reg);
                    state_next      = S_RESP;
                end
            end

            // capture the entry read
            S_READ:
            begin
                res_key_next  = 32'(rd_key);
                res_page_next = rd_page;
                res_slot_next = rd_slot;
                state_next    = S_RESP;
            end

            // hand the single result to the output register
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // decide which side the new entry joins
            S_SPLIT_CHK:
            begin
                local_next    = (req_key_reg < rd_key);
                new_done_next = (req_key_reg < rd_key);
                cur_next      = CW'(KEEP);
                sib_next      = '0;
                state_next    = S_EMIT;
            end

            // emit the sibling entries, merging the new one in sorted place
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    ld_status = ST_OK;
                    ld_pos    = 7'(sib_reg);
                    ld_count  = 7'(fill_reg) + 7'(local_reg);
                    sib_next  = sib_reg + CW'(1);
                    if (!new_done_reg && !(rd_key < req_key_reg))
                    begin
                        ld_key        = 32'(req_key_reg);
                        ld_page       = req_page_reg;
                        ld_slot       = req_slot_reg;
                        ld_last       = 1'b0;
                        new_done_next = 1'b1;
                    end
                    else
                    begin
                        ld_key  = 32'(rd_key);
                        ld_page = rd_page;
                        ld_slot = rd_slot;
                        ld_last = (cur_reg == CW'(CAPACITY - 1)) && new_done_reg;
                        if (cur_reg == CW'(CAPACITY - 1))
                        begin
                            if (!new_done_reg)
                            begin
                                state_next = S_EMIT_NEW;
                            end
                            else if (local_reg)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = fill_dec[IW-1:0];
                                cur_next   = fill_dec;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = cur_inc[IW-1:0];
                            cur_next  = cur_inc;
                        end
                    end
                end
            end

            // new entry goes after every moved one
            S_EMIT_NEW:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_status  = ST_OK;
                    ld_pos     = 7'(sib_reg);
                    ld_key     = 32'(req_key_reg);
                    ld_page    = req_page_reg;
                    ld_slot    = req_slot_reg;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            link_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            link_reg      <= link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        sib_reg        <= sib_next;
        new_done_reg   <= new_done_next;
        local_reg      <= local_next;
        req_key_reg    <= req_key_next;
        req_page_reg   <= req_page_next;
        req_slot_reg   <= req_slot_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_key_reg    <= res_key_next;
        res_page_reg   <= res_page_next;
        res_slot_reg   <= res_slot_next;
        if (out_load)
        begin
            out_status_reg <= ld_status;
            out_pos_reg    <= ld_pos;
            out_key_reg    <= ld_key;
            out_page_reg   <= ld_page;
            out_slot_reg   <= ld_slot;
            out_link_reg   <= link_reg;
            out_count_reg  <= ld_count;
            out_last_reg   <= ld_last;
        end
    end

    // result ports
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign position    = out_pos_reg;
    assign out_key     = out_key_reg;
    assign out_page    = out_page_reg;
    assign out_slot    = out_slot_reg;
    assign link_ptr    = out_link_reg;
    assign entry_count = out_count_reg;
    assign last        = out_last_reg;

endmodule
